// ===== hw/rtl/iougm_pkg.sv =====
// ----------------------------------------------------------------------------
// iougm_pkg
// shared types and constants of the greedy iou detection matcher
// ----------------------------------------------------------------------------
package iougm_pkg;

    // beat field widths
    localparam int FUNC_W  = 2;
    localparam int FIELD_W = 16;
    localparam int SCORE_W = 32;
    localparam int IDX_W   = 6;
    localparam int CFG_A_W = 8;
    localparam int CFG_D_W = 8;

    // input operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_TRUTH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_DET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL       = 2'd2;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_THRESH_NUM = 8'd0;
    localparam logic [CFG_A_W-1:0] REG_THRESH_DEN = 8'd1;

    // register reset values
    localparam logic [CFG_D_W-1:0] THRESH_NUM_RST = 8'd1;
    localparam logic [CFG_D_W-1:0] THRESH_DEN_RST = 8'd5;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SEL    = 10'b00_0000_0010,
        S_DADDR  = 10'b00_0000_0100,
        S_DFETCH = 10'b00_0000_1000,
        S_MUL    = 10'b00_0001_0000,
        S_TRD    = 10'b00_0010_0000,
        S_TCHK   = 10'b00_0100_0000,
        S_NEXTK  = 10'b00_1000_0000,
        S_ERD    = 10'b01_0000_0000,
        S_EOUT   = 10'b10_0000_0000
    } t_state;

    // jobs handed to the shared multiplier
    typedef enum logic [2:0] {
        OP_DAREA,
        OP_TAREA,
        OP_INTER,
        OP_TDEN,
        OP_NUMU,
        OP_X1,
        OP_X2
    } t_op;

endpackage

// ===== hw/rtl/iougm_ifs.sv =====
// ----------------------------------------------------------------------------
// iougm channel interfaces
// input box beats, result beats and register writes
// ----------------------------------------------------------------------------
interface iougm_in_if import iougm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [FIELD_W-1:0] box_x;
    logic signed [FIELD_W-1:0] box_y;
    logic [FIELD_W-1:0]        box_w;
    logic [FIELD_W-1:0]        box_h;
    logic signed [SCORE_W-1:0] score;

    modport source (output valid, func, box_x, box_y, box_w, box_h, score, input ready);
    modport sink   (input valid, func, box_x, box_y, box_w, box_h, score, output ready);
endinterface

interface iougm_out_if import iougm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          det_index;
    logic                      matched;
    logic signed [SCORE_W-1:0] det_score;
    logic                      dropped;
    logic                      last;

    modport source (output valid, det_index, matched, det_score, dropped, last, input ready);
    modport sink   (input valid, det_index, matched, det_score, dropped, last, output ready);
endinterface

interface iougm_cfg_if import iougm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CFG_A_W-1:0] index;
    logic [CFG_D_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/iougm_ram.sv =====
// ----------------------------------------------------------------------------
// iougm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module iougm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/iougm_mul.sv =====
// ----------------------------------------------------------------------------
// iougm_mul
// shift-add multiplier, one multiplier bit per cycle, stops early
// ----------------------------------------------------------------------------
module iougm_mul #(
    parameter int MW = 33
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MW-1:0]   i_a,
    input  logic [MW-1:0]   i_b,
    output logic            o_done,
    output logic [2*MW-1:0] o_prod
);
    logic            r_busy;
    logic            r_done;
    logic [2*MW-1:0] r_acc;
    logic [2*MW-1:0] r_a;
    logic [MW-1:0]   r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_b == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= {{MW{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== hw/rtl/iou_greedy_detection_matcher.sv =====
// ----------------------------------------------------------------------------
// iou_greedy_detection_matcher
// greedy iou matching of scored detections against ground-truth boxes
// ----------------------------------------------------------------------------
// load beats are taken while idle and leave the block ready for the next beat
// evaluate: per visited detection a score scan over the loaded detections, then per
//   truth box a check of its taken flag plus up to six multiplies on the one shared
//   shift-add multiplier (stops early on zeros)
// results leave in load order, each through a read state and an output state, then ready again
// reset (synchronous, active low) clears counts and flags and sets the thresholds to 1/5
// ----------------------------------------------------------------------------
module iou_greedy_detection_matcher import iougm_pkg::*; #(
    parameter int MAX_TRUTH  = 64,
    parameter int MAX_DETS   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iougm_in_if.sink      i_in,
    iougm_out_if.source   o_out,
    iougm_cfg_if.sink     i_cfg
);
    localparam int CB  = COORD_BITS;
    localparam int MW  = 2 * CB + 1;              // union width, widest operand
    localparam int PW  = 2 * MW;
    localparam int TAW = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
    localparam int TCW = $clog2(MAX_TRUTH + 1);
    localparam int DAW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
    localparam int DCW = $clog2(MAX_DETS + 1);
    localparam int TBW = 4 * CB;
    localparam int DBW = 4 * CB + SCORE_W;

    // state and registers
    t_state r_state, n_state;
    t_op    r_op;

    logic [CFG_D_W-1:0] r_num, r_den;
    logic [TCW-1:0]     r_tc, r_nt, r_j;
    logic [DCW-1:0]     r_dc, r_nd, r_i, r_k;
    logic               r_drop, r_drop_ev;
    logic [MAX_DETS-1:0] r_visited, r_matched;

    // selection scan
    logic               r_sel_v;
    logic [DAW-1:0]     r_sel_idx;
    logic               r_sel_have;
    logic [DAW-1:0]     r_pick;
    logic signed [SCORE_W-1:0] r_best_score;

    // current detection and truth
    logic [CB-1:0]      r_dx, r_dy, r_dw, r_dh;
    logic [CB-1:0]      r_iw, r_ih;
    logic [2*CB-1:0]    r_darea, r_tarea, r_inter, r_bi;
    logic [MW-1:0]      r_union, r_bu;
    logic [PW-1:0]      r_p1;
    logic               r_have;
    logic [TAW-1:0]     r_best;

    // output register
    logic               r_ov;
    logic [DAW-1:0]     r_e;
    logic [IDX_W-1:0]   r_o_idx;
    logic               r_o_match, r_o_drop, r_o_last;
    logic signed [SCORE_W-1:0] r_o_score;

    // shared multiplier
    logic               r_mul_start;
    logic [MW-1:0]      r_mul_a, r_mul_b;
    logic               mul_done;
    logic [PW-1:0]      mul_prod;

    // memories
    logic               t_we, k_we, d_we, k_wdata;
    logic [TAW-1:0]     t_waddr, t_raddr, k_waddr;
    logic [DAW-1:0]     d_waddr, d_raddr;
    logic [TBW-1:0]     t_wdata, t_rdata;
    logic [DBW-1:0]     d_wdata, d_rdata;
    logic               k_rdata;

    // beat decode
    logic               in_beat, load_t, load_d, eval_beat, out_free;
    logic [31:0]        ext_x, ext_y, ext_w, ext_h;
    logic [TBW-1:0]     in_box;

    // geometry of the pair under test
    logic [CB-1:0]      tx, ty, tw, th;
    logic signed [SCORE_W-1:0] rd_score;
    logic [MW-1:0]      n_union;

    function automatic logic [CB-1:0] overlap(input logic [CB-1:0] a0, input logic [CB-1:0] al,
                                              input logic [CB-1:0] b0, input logic [CB-1:0] bl);
        logic signed [CB+1:0] sa0, sa1, sb0, sb1, lo, hi, dif;
        sa0 = {{2{a0[CB-1]}}, a0};
        sb0 = {{2{b0[CB-1]}}, b0};
        sa1 = sa0 + $signed({2'b00, al});
        sb1 = sb0 + $signed({2'b00, bl});
        lo  = (sa0 > sb0) ? sa0 : sb0;
        hi  = (sa1 < sb1) ? sa1 : sb1;
        dif = hi - lo;
        return (hi > lo) ? dif[CB-1:0] : '0;
    endfunction

    assign ext_x  = {16'b0, i_in.box_x};
    assign ext_y  = {16'b0, i_in.box_y};
    assign ext_w  = {16'b0, i_in.box_w};
    assign ext_h  = {16'b0, i_in.box_h};
    assign in_box = {ext_x[CB-1:0], ext_y[CB-1:0], ext_w[CB-1:0], ext_h[CB-1:0]};

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_beat   = i_in.valid && i_in.ready;
    assign load_t    = in_beat && (i_in.func == FUNC_LOAD_TRUTH);
    assign load_d    = in_beat && (i_in.func == FUNC_LOAD_DET);
    assign eval_beat = in_beat && (i_in.func == FUNC_EVAL);
    assign out_free  = !r_ov || o_out.ready;

    // truth boxes written at the fill count; reads stay below it
    assign t_we    = load_t && (r_tc < TCW'(MAX_TRUTH));
    assign t_waddr = r_tc[TAW-1:0];
    assign t_wdata = in_box;
    assign t_raddr = r_j[TAW-1:0];

    // taken flag: cleared by the load of its box, set by a match
    assign k_we    = t_we || ((r_state == S_NEXTK) && r_have);
    assign k_waddr = t_we ? r_tc[TAW-1:0] : r_best;
    assign k_wdata = !t_we;

    assign d_we    = load_d && (r_dc < DCW'(MAX_DETS));
    assign d_waddr = r_dc[DAW-1:0];
    assign d_wdata = {in_box, i_in.score};

    always_comb begin
        case (r_state)
            S_SEL:   d_raddr = r_i[DAW-1:0];
            S_DADDR: d_raddr = r_pick;
            default: d_raddr = r_e;
        endcase
    end

    iougm_ram #(.WIDTH(TBW), .DEPTH(MAX_TRUTH)) u_truth_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    iougm_ram #(.WIDTH(1), .DEPTH(MAX_TRUTH)) u_taken_ram (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(k_wdata),
        .i_raddr(t_raddr), .o_rdata(k_rdata)
    );

    iougm_ram #(.WIDTH(DBW), .DEPTH(MAX_DETS)) u_det_ram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    iougm_mul #(.MW(MW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mul_start),
        .i_a(r_mul_a), .i_b(r_mul_b), .o_done(mul_done), .o_prod(mul_prod)
    );

    assign tx       = t_rdata[4*CB-1:3*CB];
    assign ty       = t_rdata[3*CB-1:2*CB];
    assign tw       = t_rdata[2*CB-1:CB];
    assign th       = t_rdata[CB-1:0];
    assign rd_score = d_rdata[SCORE_W-1:0];
    assign n_union  = MW'(r_tarea) + MW'(r_darea) - MW'(mul_prod[2*CB-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (eval_beat && (r_dc != '0)) n_state = S_SEL;
            S_SEL:    if (r_sel_v && (DCW'(r_sel_idx) == r_nd - 1'b1)) n_state = S_DADDR;
            S_DADDR:  n_state = S_DFETCH;
            S_DFETCH: n_state = S_MUL;
            S_TRD:    n_state = (r_j >= r_nt) ? S_NEXTK : S_TCHK;
            S_TCHK:   n_state = k_rdata ? S_TRD : S_MUL;
            S_MUL: begin
                if (mul_done) begin
                    case (r_op)
                        OP_DAREA: n_state = S_TRD;
                        OP_INTER: if (n_union == '0) n_state = S_TRD;
                        OP_NUMU:  if ((r_p1 < mul_prod) || !r_have) n_state = S_TRD;
                        OP_X2:    n_state = S_TRD;
                        default:  n_state = S_MUL;
                    endcase
                end
            end
            S_NEXTK:  n_state = (r_k + 1'b1 == r_nd) ? S_ERD : S_SEL;
            S_ERD:    n_state = S_EOUT;
            S_EOUT:   if (out_free) n_state = (DCW'(r_e) == r_nd - 1'b1) ? S_IDLE : S_ERD;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= THRESH_NUM_RST;
            r_den       <= THRESH_DEN_RST;
            r_tc        <= '0;
            r_dc        <= '0;
            r_drop      <= 1'b0;
            r_ov        <= 1'b0;
            r_mul_start <= 1'b0;
            r_sel_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mul_start <= 1'b0;

            if (i_cfg.valid) begin
                if (i_cfg.index == REG_THRESH_NUM) r_num <= i_cfg.data;
                if (i_cfg.index == REG_THRESH_DEN) r_den <= i_cfg.data;
            end

            // loads, overflow flag; evaluate hands the counts over and clears them
            if (load_t) begin
                if (t_we) r_tc <= r_tc + 1'b1;
                else      r_drop <= 1'b1;
            end
            if (load_d) begin
                if (d_we) r_dc <= r_dc + 1'b1;
                else      r_drop <= 1'b1;
            end
            if (eval_beat) begin
                r_tc   <= '0;
                r_dc   <= '0;
                r_drop <= 1'b0;
            end

            if (o_out.ready) r_ov <= 1'b0;
            if ((r_state == S_EOUT) && out_free) r_ov <= 1'b1;

            // selection scan: read data arrives the cycle after its address
            if (r_state == S_SEL) begin
                r_sel_v <= (r_i < r_nd);
            end else begin
                r_sel_v <= 1'b0;
            end

            // jobs for the multiplier
            if (r_state == S_DFETCH) r_mul_start <= 1'b1;
            if ((r_state == S_TCHK) && !k_rdata) r_mul_start <= 1'b1;
            if ((r_state == S_MUL) && mul_done) begin
                case (r_op)
                    OP_TAREA: r_mul_start <= 1'b1;
                    OP_INTER: r_mul_start <= (n_union != '0);
                    OP_TDEN:  r_mul_start <= 1'b1;
                    OP_NUMU:  r_mul_start <= !(r_p1 < mul_prod) && r_have;
                    OP_X1:    r_mul_start <= 1'b1;
                    default:  r_mul_start <= 1'b0;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (eval_beat) begin
                    r_nd      <= r_dc;
                    r_nt      <= r_tc;
                    r_drop_ev <= r_drop;
                    r_k       <= '0;
                    r_i       <= '0;
                    r_sel_have <= 1'b0;
                    r_visited <= '0;
                    r_matched <= '0;
                    r_e       <= '0;
                end
            end
            S_SEL: begin
                if (r_i < r_nd) r_i <= r_i + 1'b1;
                r_sel_idx <= r_i[DAW-1:0];
                // highest score wins, equal scores keep the lower index
                if (r_sel_v && !r_visited[r_sel_idx] &&
                    (!r_sel_have || (rd_score > r_best_score))) begin
                    r_sel_have   <= 1'b1;
                    r_pick       <= r_sel_idx;
                    r_best_score <= rd_score;
                end
            end
            S_DADDR: begin
                r_visited[r_pick] <= 1'b1;
            end
            S_DFETCH: begin
                r_dx    <= d_rdata[4*CB+SCORE_W-1:3*CB+SCORE_W];
                r_dy    <= d_rdata[3*CB+SCORE_W-1:2*CB+SCORE_W];
                r_dw    <= d_rdata[2*CB+SCORE_W-1:CB+SCORE_W];
                r_dh    <= d_rdata[CB+SCORE_W-1:SCORE_W];
                r_op    <= OP_DAREA;
                r_mul_a <= MW'(d_rdata[2*CB+SCORE_W-1:CB+SCORE_W]);
                r_mul_b <= MW'(d_rdata[CB+SCORE_W-1:SCORE_W]);
                r_j     <= '0;
                r_have  <= 1'b0;
            end
            S_TRD: ;
            S_TCHK: begin
                if (k_rdata) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    r_iw    <= overlap(tx, tw, r_dx, r_dw);
                    r_ih    <= overlap(ty, th, r_dy, r_dh);
                    r_op    <= OP_TAREA;
                    r_mul_a <= MW'(tw);
                    r_mul_b <= MW'(th);
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    case (r_op)
                        OP_DAREA: r_darea <= mul_prod[2*CB-1:0];
                        OP_TAREA: begin
                            r_tarea <= mul_prod[2*CB-1:0];
                            r_op    <= OP_INTER;
                            r_mul_a <= MW'(r_iw);
                            r_mul_b <= MW'(r_ih);
                        end
                        OP_INTER: begin
                            r_inter <= mul_prod[2*CB-1:0];
                            r_union <= n_union;
                            if (n_union == '0) r_j <= r_j + 1'b1;  // empty union never matches
                            r_op    <= OP_TDEN;
                            r_mul_a <= MW'(mul_prod[2*CB-1:0]);
                            r_mul_b <= MW'(r_den);
                        end
                        OP_TDEN: begin
                            r_p1    <= mul_prod;
                            r_op    <= OP_NUMU;
                            r_mul_a <= r_union;
                            r_mul_b <= MW'(r_num);
                        end
                        OP_NUMU: begin
                            if (r_p1 < mul_prod) begin
                                r_j <= r_j + 1'b1;             // below threshold
                            end else if (!r_have) begin
                                r_have <= 1'b1;
                                r_best <= r_j[TAW-1:0];
                                r_bi   <= r_inter;
                                r_bu   <= r_union;
                                r_j    <= r_j + 1'b1;
                            end
                            r_op    <= OP_X1;
                            r_mul_a <= MW'(r_inter);
                            r_mul_b <= r_bu;
                        end
                        OP_X1: begin
                            r_p1    <= mul_prod;
                            r_op    <= OP_X2;
                            r_mul_a <= MW'(r_bi);
                            r_mul_b <= r_union;
                        end
                        OP_X2: begin
                            // strictly better iou only, ties keep the lower truth
                            if (r_p1 > mul_prod) begin
                                r_best <= r_j[TAW-1:0];
                                r_bi   <= r_inter;
                                r_bu   <= r_union;
                            end
                            r_j <= r_j + 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_NEXTK: begin
                if (r_have) r_matched[r_pick] <= 1'b1;
                r_k        <= r_k + 1'b1;
                r_i        <= '0;
                r_sel_have <= 1'b0;
            end
            S_ERD: ;
            S_EOUT: begin
                if (out_free) begin
                    r_o_idx   <= IDX_W'(r_e);
                    r_o_match <= r_matched[r_e];
                    r_o_score <= rd_score;
                    r_o_drop  <= r_drop_ev;
                    r_o_last  <= (DCW'(r_e) == r_nd - 1'b1);
                    r_e       <= r_e + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid     = r_ov;
    assign o_out.det_index = r_o_idx;
    assign o_out.matched   = r_o_match;
    assign o_out.det_score = r_o_score;
    assign o_out.dropped   = r_o_drop;
    assign o_out.last      = r_o_last;
endmodule

// ===== hw/rtl/iougm_chk.sv =====
// ----------------------------------------------------------------------------
// iougm_chk
// port-level checks of the matcher, bound to the top level
// ----------------------------------------------------------------------------
module iougm_chk import iougm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [FUNC_W-1:0] i_in_func,
    input logic              o_out_valid,
    input logic              o_out_ready,
    input logic              o_out_last,
    input logic              i_cfg_ready
);
    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a load beat leaves the block ready on the next cycle
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_func == FUNC_LOAD_TRUTH || i_in_func == FUNC_LOAD_DET) |=> i_in_ready)
        else $error("load beat stalled the input");

    // nothing directly follows the final result beat once it is taken
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_ready && o_out_last |=> !o_out_valid)
        else $error("result after final beat");

    // the input stays closed while an evaluation still owes results
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_last |-> !i_in_ready)
        else $error("input open during result stream");

    // register writes are never refused
    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register write refused");
endmodule

bind iou_greedy_detection_matcher iougm_chk u_iougm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .o_out_valid (o_out.valid),
    .o_out_ready (o_out.ready),
    .o_out_last  (o_out.last),
    .i_cfg_ready (i_cfg.ready)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the greedy iou detection matcher: box images are
// streamed in with random gaps, each evaluate is predicted in the bench and
// every result beat is compared against the expected one in load order
// ----------------------------------------------------------------------------
module tb_top;
    import iougm_pkg::*;

    localparam int NUM_TRUTH  = 64;
    localparam int NUM_DETS   = 64;
    localparam int RAND_ITEMS = 130;
    localparam int MIN_PHASES = 4;
    localparam int LIMIT      = 3000000;
    localparam int SETTLE     = 200;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // one box beat as it goes over the input channel
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic [FIELD_W-1:0]        w;
        logic [FIELD_W-1:0]        h;
        logic signed [SCORE_W-1:0] score;
    } box_beat_t;

    // one result beat
    typedef struct packed {
        logic [IDX_W-1:0]          det_index;
        logic                      matched;
        logic signed [SCORE_W-1:0] det_score;
        logic                      dropped;
        logic                      last;
    } match_res_t;

    logic i_clk;
    logic i_rst_n;

    iougm_in_if  in_ch ();
    iougm_out_if out_ch ();
    iougm_cfg_if cfg_ch ();

    iou_greedy_detection_matcher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // stimulus and expectation stores
    box_beat_t  box_queue[$];
    match_res_t match_queue[$];
    int         errors;
    int         cycle_cnt;

    // traffic shaping: calm turns off random idling on both sides,
    // stall_go asks for one long receiver hold-off
    bit         calm;
    bit         stall_go;
    bit         stall_done;
    int         stall_left;

    // predictor state
    box_beat_t   truth_mem[NUM_TRUTH];
    box_beat_t   det_mem[NUM_DETS];
    int          truth_cnt;
    int          det_cnt;
    bit          overflow;
    logic [7:0]  th_num;
    logic [7:0]  th_den;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // overlap of the spans [a0, a0+al) and [b0, b0+bl)
    function automatic longint span_overlap(longint a0, longint al, longint b0, longint bl);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // greedy claim of the best untaken truth box for one detection
    function automatic bit claim_truth(int di, ref bit taken[NUM_TRUTH]);
        bit           have;
        int           best;
        longint       inter;
        longint       uni;
        longint       iw;
        longint       ih;
        longint       b_inter;
        longint       b_uni;
        logic [127:0] lhs;
        logic [127:0] rhs;
        box_beat_t    t;
        box_beat_t    d;
        have    = 0;
        best    = 0;
        b_inter = 0;
        b_uni   = 1;
        d       = det_mem[di];
        for (int j = 0; j < truth_cnt; j++) begin
            if (taken[j])
                continue;
            t  = truth_mem[j];
            iw = span_overlap(longint'(t.x), longint'(t.w), longint'(d.x), longint'(d.w));
            ih = span_overlap(longint'(t.y), longint'(t.h), longint'(d.y), longint'(d.h));
            inter = (iw == 0 || ih == 0) ? 0 : iw * ih;
            uni = longint'(t.w) * longint'(t.h) + longint'(d.w) * longint'(d.h) - inter;
            // zero union never matches
            if (uni == 0)
                continue;
            // threshold test by cross-multiplication, zero denominator as is
            if (inter * longint'(th_den) < longint'(th_num) * uni)
                continue;
            lhs = 128'(inter) * 128'(b_uni);
            rhs = 128'(b_inter) * 128'(uni);
            if (!have || lhs > rhs) begin
                have    = 1;
                best    = j;
                b_inter = inter;
                b_uni   = uni;
            end
        end
        if (have)
            taken[best] = 1;
        return have;
    endfunction

    // update model state on one accepted beat, queue any expected results
    function automatic void predict_beat(box_beat_t b);
        bit         taken[NUM_TRUTH];
        bit         matched[NUM_DETS];
        bit         visited[NUM_DETS];
        bit         have;
        int         pick;
        match_res_t r;
        case (b.func)
            FUNC_LOAD_TRUTH: begin
                if (truth_cnt < NUM_TRUTH) begin
                    truth_mem[truth_cnt] = b;
                    truth_cnt++;
                end else begin
                    overflow = 1;
                end
            end
            FUNC_LOAD_DET: begin
                if (det_cnt < NUM_DETS) begin
                    det_mem[det_cnt] = b;
                    det_cnt++;
                end else begin
                    overflow = 1;
                end
            end
            FUNC_EVAL: begin
                for (int i = 0; i < NUM_TRUTH; i++) taken[i] = 0;
                for (int i = 0; i < NUM_DETS; i++) begin
                    matched[i] = 0;
                    visited[i] = 0;
                end
                // visit in descending score, ties to the lower index
                for (int k = 0; k < det_cnt; k++) begin
                    have = 0;
                    pick = 0;
                    for (int i = 0; i < det_cnt; i++) begin
                        if (visited[i])
                            continue;
                        if (!have || det_mem[i].score > det_mem[pick].score) begin
                            have = 1;
                            pick = i;
                        end
                    end
                    visited[pick] = 1;
                    matched[pick] = claim_truth(pick, taken);
                end
                for (int i = 0; i < det_cnt; i++) begin
                    r.det_index = IDX_W'(i);
                    r.matched   = matched[i];
                    r.det_score = det_mem[i].score;
                    r.dropped   = overflow;
                    r.last      = (i + 1 == det_cnt);
                    match_queue.push_back(r);
                end
                truth_cnt = 0;
                det_cnt   = 0;
                overflow  = 0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // input driver: takes beats from box_queue, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        box_beat_t nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.func  <= FUNC_LOAD_TRUTH;
            in_ch.box_x <= '0;
            in_ch.box_y <= '0;
            in_ch.box_w <= '0;
            in_ch.box_h <= '0;
            in_ch.score <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_beat({in_ch.func, in_ch.box_x, in_ch.box_y,
                              in_ch.box_w, in_ch.box_h, in_ch.score});
            if (!in_ch.valid || in_ch.ready) begin
                if (box_queue.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
                    nxt = box_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.func  <= nxt.func;
                    in_ch.box_x <= nxt.x;
                    in_ch.box_y <= nxt.y;
                    in_ch.box_w <= nxt.w;
                    in_ch.box_h <= nxt.h;
                    in_ch.score <= nxt.score;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_go && !stall_done) begin
            stall_left <= 600;
            stall_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random ready, compare each beat with the oldest expected
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        match_res_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (match_queue.size() == 0) begin
                    $display("%0t unexpected result beat idx %0d", $time, out_ch.det_index);
                    errors++;
                end else begin
                    want = match_queue.pop_front();
                    if (out_ch.det_index !== want.det_index) begin
                        $display("%0t det_index exp %0d got %0d", $time,
                                 want.det_index, out_ch.det_index);
                        errors++;
                    end
                    if (out_ch.matched !== want.matched) begin
                        $display("%0t matched idx %0d exp %0d got %0d", $time,
                                 want.det_index, want.matched, out_ch.matched);
                        errors++;
                    end
                    if (out_ch.det_score !== want.det_score) begin
                        $display("%0t det_score idx %0d exp %h got %h", $time,
                                 want.det_index, want.det_score, out_ch.det_score);
                        errors++;
                    end
                    if (out_ch.dropped !== want.dropped) begin
                        $display("%0t dropped idx %0d exp %0d got %0d", $time,
                                 want.det_index, want.dropped, out_ch.dropped);
                        errors++;
                    end
                    if (out_ch.last !== want.last) begin
                        $display("%0t last idx %0d exp %0d got %0d", $time,
                                 want.det_index, want.last, out_ch.last);
                        errors++;
                    end
                end
            end
            out_ch.ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 29);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_box(logic [FUNC_W-1:0] f, int x, int y, int w, int h, int s);
        box_beat_t b;
        b.func  = f;
        b.x     = FIELD_W'(x);
        b.y     = FIELD_W'(y);
        b.w     = FIELD_W'(w);
        b.h     = FIELD_W'(h);
        b.score = s;
        box_queue.push_back(b);
    endtask

    // fully random bits in every box field and the score
    task automatic push_noise(logic [FUNC_W-1:0] f);
        push_box(f, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // one image: clustered truths, detections jittered around them, then evaluate
    task automatic push_image(int n_truth, int n_det, ref int cnt);
        int cx;
        int cy;
        int tx[8];
        int ty[8];
        int tw[8];
        int th[8];
        int k;
        int sc;
        cx = $urandom_range(400) - 200;
        cy = $urandom_range(400) - 200;
        for (int j = 0; j < n_truth; j++) begin
            tx[j] = cx + $urandom_range(40) - 20;
            ty[j] = cy + $urandom_range(40) - 20;
            tw[j] = $urandom_range(60, 1);
            th[j] = $urandom_range(60, 1);
            if ($urandom_range(9) == 0)
                push_noise(FUNC_LOAD_TRUTH);
            else
                push_box(FUNC_LOAD_TRUTH, tx[j], ty[j], tw[j], th[j], $urandom);
            cnt++;
        end
        for (int i = 0; i < n_det; i++) begin
            // scores from a narrow set give plenty of ties
            sc = ($urandom_range(2) == 0) ? $urandom : ($urandom_range(7) << 16);
            if (n_truth == 0 || $urandom_range(7) == 0) begin
                push_noise(FUNC_LOAD_DET);
            end else begin
                k = $urandom_range(n_truth - 1);
                push_box(FUNC_LOAD_DET, tx[k] + $urandom_range(16) - 8,
                         ty[k] + $urandom_range(16) - 8,
                         tw[k] + $urandom_range(16) - 8, th[k] + $urandom_range(16) - 8, sc);
            end
            cnt++;
            if ($urandom_range(19) == 0) begin
                push_noise(FUNC_NONE);
                cnt++;
            end
        end
        push_noise(FUNC_EVAL);
        cnt++;
    endtask

    // let everything queued drain, then give the block time to go idle
    task automatic drain();
        while (box_queue.size() > 0 || in_ch.valid || match_queue.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        th_num = (idx == REG_THRESH_NUM) ? val : th_num;
        th_den = (idx == REG_THRESH_DEN) ? val : th_den;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int cnt;
        int ph;
        calm         = 0;
        stall_go     = 0;
        truth_cnt    = 0;
        det_cnt      = 0;
        overflow     = 0;
        th_num       = THRESH_NUM_RST;
        th_den       = THRESH_DEN_RST;
        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_THRESH_NUM;
        cfg_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset thresholds of one fifth
        // empty evaluate gives nothing
        push_box(FUNC_EVAL, 0, 0, 0, 0, 0);
        // exactly at threshold: 20 / 100
        push_box(FUNC_LOAD_TRUTH, 0, 0, 10, 10, 0);
        // identical truth, tie in iou goes to the lower index
        push_box(FUNC_LOAD_TRUTH, 0, 0, 10, 10, 0);
        // zero-area truth, zero union against a zero-area detection
        push_box(FUNC_LOAD_TRUTH, 5, 5, 0, 0, 0);
        // extreme coordinates and sizes
        push_box(FUNC_LOAD_TRUTH, -32768, -32768, 65535, 65535, 0);
        push_box(FUNC_LOAD_DET, 0, 0, 10, 2, 32'sh0001_0000);
        push_box(FUNC_LOAD_DET, 0, 0, 10, 10, 32'sh0001_0000);
        push_box(FUNC_LOAD_DET, 5, 5, 0, 0, 32'sh7fff_ffff);
        push_box(FUNC_LOAD_DET, 32767, 32767, 65535, 65535, 32'sh8000_0000);
        push_box(FUNC_LOAD_DET, -32768, -32768, 65535, 65535, -1);
        push_box(FUNC_NONE, 32767, 32767, 65535, 65535, -1);
        push_box(FUNC_LOAD_DET, 1, 1, 9, 1, 0);
        push_box(FUNC_EVAL, -1, -1, 65535, 65535, -1);
        drain();

        // store overflow, cheap zero-size boxes keep the evaluate short
        for (int j = 0; j < NUM_TRUTH + 2; j++)
            push_box(FUNC_LOAD_TRUTH, j, 0, 0, 0, 0);
        push_box(FUNC_LOAD_DET, 0, 0, 0, 0, 5);
        push_box(FUNC_EVAL, 0, 0, 0, 0, 0);
        for (int i = 0; i < NUM_DETS + 1; i++)
            push_box(FUNC_LOAD_DET, i, 0, 0, 0, $urandom_range(3));
        push_box(FUNC_LOAD_TRUTH, 0, 0, 0, 0, 0);
        push_box(FUNC_EVAL, 0, 0, 0, 0, 0);
        // the flag is cleared by the evaluate
        push_box(FUNC_LOAD_DET, 0, 0, 4, 4, 9);
        push_box(FUNC_EVAL, 0, 0, 0, 0, 0);
        drain();

        // random images over several threshold settings
        cnt = 0;
        ph  = 0;
        while (cnt < RAND_ITEMS || ph < MIN_PHASES) begin
            case (ph % 7)
                0: begin write_reg(REG_THRESH_NUM, 8'd0);   write_reg(REG_THRESH_DEN, 8'd1);   end
                1: begin write_reg(REG_THRESH_NUM, 8'd255); write_reg(REG_THRESH_DEN, 8'd255); end
                2: begin write_reg(REG_THRESH_NUM, 8'd1);   write_reg(REG_THRESH_DEN, 8'd2);   end
                3: begin write_reg(REG_THRESH_NUM, 8'd0);   write_reg(REG_THRESH_DEN, 8'd0);   end
                4: begin write_reg(REG_THRESH_NUM, 8'd3);   write_reg(REG_THRESH_DEN, 8'd0);   end
                5: begin write_reg(REG_THRESH_NUM, 8'd255); write_reg(REG_THRESH_DEN, 8'd1);   end
                default: begin
                    write_reg(REG_THRESH_NUM, 8'($urandom_range(255)));
                    write_reg(REG_THRESH_DEN, 8'($urandom_range(255, 1)));
                end
            endcase
            // one phase with no idling, one with the long hold-off
            calm     = (ph == 2);
            stall_go = (ph == 3);
            for (int m = 0; m < 5; m++)
                push_image($urandom_range(6), $urandom_range(6, 1), cnt);
            drain();
            calm = 0;
            ph++;
        end

        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
